### hw/rtl/fair_share_task_scheduler_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the fair-share task scheduler
// Clocked property checks that compile away in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef FAIR_SHARE_TASK_SCHEDULER_UNIT_ASSERT_SVH
`define FAIR_SHARE_TASK_SCHEDULER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define FSTS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FSTS_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FSTS_ASSERT(label, clk, rst, prop, msg)
`define FSTS_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

### hw/rtl/fsts_pkg.sv
// ---------------------------------------------------------------------------
// fsts_pkg
// Shared widths, codes, the weight table and helpers of the scheduler.
// ---------------------------------------------------------------------------
package fsts_pkg;

   localparam int unsigned MAX_TASKS_DEF = 16;
   localparam int unsigned VR_W          = 64;
   localparam int unsigned WEIGHT_W      = 17;
   localparam int unsigned STAMP_W       = 32;
   localparam int unsigned RUNTIME_W     = 40;
   localparam int unsigned SLICE_W       = 20;
   localparam int unsigned UNIT_SHIFT    = 10;   // times 1024
   localparam int unsigned DIV_NUM_W     = RUNTIME_W + UNIT_SHIFT;
   localparam int unsigned PRIO_TOP      = 39;

   localparam logic [SLICE_W-1:0] SLICE_MAX     = '1;
   localparam logic [SLICE_W-1:0] LATENCY_RST   = 20'd20000;
   localparam logic [SLICE_W-1:0] MIN_SLICE_RST = 20'd1000;

   localparam logic [2:0] OP_ENQUEUE = 3'd0;
   localparam logic [2:0] OP_PICK    = 3'd1;
   localparam logic [2:0] OP_PUTBACK = 3'd2;
   localparam logic [2:0] OP_QUERY   = 3'd3;
   localparam logic [2:0] OP_CLEAR   = 3'd4;

   localparam logic [1:0] STS_OK     = 2'd0;
   localparam logic [1:0] STS_EMPTY  = 2'd1;
   localparam logic [1:0] STS_QUEUED = 2'd2;
   localparam logic [1:0] STS_BAD_OP = 2'd3;

   localparam logic CSR_LATENCY   = 1'b0;
   localparam logic CSR_MIN_SLICE = 1'b1;

   typedef struct packed {
      logic [VR_W-1:0]     vruntime;
      logic [WEIGHT_W-1:0] weight;
      logic [STAMP_W-1:0]  stamp;
   } fsts_entry_type;

   typedef struct packed {
      logic busy;
      logic done;
   } fsts_div_stat_type;

   function automatic logic [WEIGHT_W-1:0] weight_of(input logic [5:0] idx);
      logic [WEIGHT_W-1:0] w;
      case (idx)
         6'd0:  w = 17'd88761;  6'd1:  w = 17'd71755;  6'd2:  w = 17'd56483;
         6'd3:  w = 17'd46273;  6'd4:  w = 17'd36291;  6'd5:  w = 17'd29154;
         6'd6:  w = 17'd23254;  6'd7:  w = 17'd18705;  6'd8:  w = 17'd14949;
         6'd9:  w = 17'd11916;  6'd10: w = 17'd9548;   6'd11: w = 17'd7620;
         6'd12: w = 17'd6100;   6'd13: w = 17'd4904;   6'd14: w = 17'd3906;
         6'd15: w = 17'd3121;   6'd16: w = 17'd2501;   6'd17: w = 17'd1991;
         6'd18: w = 17'd1586;   6'd19: w = 17'd1277;   6'd20: w = 17'd1024;
         6'd21: w = 17'd820;    6'd22: w = 17'd655;    6'd23: w = 17'd526;
         6'd24: w = 17'd423;    6'd25: w = 17'd335;    6'd26: w = 17'd272;
         6'd27: w = 17'd215;    6'd28: w = 17'd172;    6'd29: w = 17'd137;
         6'd30: w = 17'd110;    6'd31: w = 17'd87;     6'd32: w = 17'd70;
         6'd33: w = 17'd56;     6'd34: w = 17'd45;     6'd35: w = 17'd36;
         6'd36: w = 17'd29;     6'd37: w = 17'd23;     6'd38: w = 17'd18;
         default: w = 17'd15;
      endcase
      return w;
   endfunction

   // 4-bit id folded onto the slot count; m >= 2 so eight subtracts suffice
   function automatic logic [7:0] fold_id(input logic [3:0] id, input int unsigned m);
      logic [7:0] r;
      r = {4'd0, id};
      for (int k = 0; k < 8; k++) begin
         if (32'(r) >= m) r = 8'(32'(r) - m);
      end
      return r;
   endfunction

endpackage

### hw/rtl/fsts_task_mem.sv
// ---------------------------------------------------------------------------
// fsts_task_mem
// Per-task table: one write port, one registered read port, valid bits.
// ---------------------------------------------------------------------------
module fsts_task_mem #(
   parameter int unsigned MAX_TASKS = fsts_pkg::MAX_TASKS_DEF,
   parameter int unsigned AW        = $clog2(MAX_TASKS)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   clr,
   input  logic                   we,
   input  logic [AW-1:0]          waddr,
   input  fsts_pkg::fsts_entry_type wdata,
   input  logic [AW-1:0]          raddr,
   output fsts_pkg::fsts_entry_type rdata
);
   import fsts_pkg::*;

   fsts_entry_type        mem [MAX_TASKS];
   logic [MAX_TASKS-1:0]  valid_ff;
   fsts_entry_type        rd_ff;
   logic                  rd_valid_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset || clr) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (we) valid_ff[waddr] <= 1'b1;
         rd_valid_ff <= valid_ff[raddr];
      end
   end

   // never-written entries read as zero
   assign rdata = rd_valid_ff ? rd_ff : '0;

endmodule

### hw/rtl/fsts_div.sv
// ---------------------------------------------------------------------------
// fsts_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module fsts_div #(
   parameter int unsigned NW = fsts_pkg::DIV_NUM_W,
   parameter int unsigned DW = 21
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [NW-1:0]                dividend,
   input  logic [DW-1:0]                divisor,
   output logic [NW-1:0]                quotient,
   output fsts_pkg::fsts_div_stat_type  stat
);
   import fsts_pkg::*;

   localparam int unsigned CNT_W = $clog2(NW + 1);

   logic [NW-1:0]    quo_ff, quo_in;
   logic [DW-1:0]    rem_ff, rem_in;
   logic [DW-1:0]    dsr_ff, dsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [DW:0]      trial;
   logic             take;

   always_comb begin
      trial  = {rem_ff, quo_ff[NW-1]};
      take   = trial >= {1'b0, dsr_ff};
      quo_in = quo_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = CNT_W'(NW);
      end else if (cnt_ff != '0) begin
         rem_in  = take ? DW'(trial - {1'b0, dsr_ff}) : trial[DW-1:0];
         quo_in  = {quo_ff[NW-2:0], take};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign quotient  = quo_ff;
   assign stat.busy = (cnt_ff != '0);
   assign stat.done = done_ff;

endmodule

### hw/rtl/fair_share_task_scheduler_unit.sv
// ---------------------------------------------------------------------------
// fair_share_task_scheduler_unit
// Fair-share scheduler: task table in memory, scan for least vruntime,
// shared serial divider for charge and timeslice.
// ---------------------------------------------------------------------------
// Channel   Dir  Handshake            Payload
// req_      in   req_valid/req_stall  opcode, task_id, priority, runtime, runnable
// rsp_      out  rsp_valid/rsp_stall  status, pick, vruntime, slice, count
// csr_      in   csr_wr_en            index, 20-bit data
//
// One item at a time. Each scan of the table reads one entry per memory
// read. Enqueue scans once; pick scans, takes the best and scans again;
// put back divides, then scans; query divides unless no weight is queued.
// Reset is synchronous; clear empties the table via valid bits.
// A result waiting under rsp_stall does not block the next accept; the block
// holds req_stall only while it works on an item or owns an unsent result.
// ---------------------------------------------------------------------------
`include "fair_share_task_scheduler_unit_assert.svh"

module fair_share_task_scheduler_unit #(
   parameter int unsigned MAX_TASKS = fsts_pkg::MAX_TASKS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [2:0]                        req_opcode,
   input  logic [3:0]                        req_task_id,
   input  logic signed [6:0]                 req_priority_req,
   input  logic [fsts_pkg::RUNTIME_W-1:0]    req_runtime_ns,
   input  logic                              req_still_runnable,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_status,
   output logic [3:0]                        rsp_picked_task,
   output logic [fsts_pkg::VR_W-1:0]         rsp_picked_vruntime,
   output logic [fsts_pkg::SLICE_W-1:0]      rsp_timeslice_us,
   output logic [4:0]                        rsp_queued_count,
   output logic                              rsp_has_queued,
   input  logic                              csr_wr_en,
   input  logic                              csr_index,
   input  logic [fsts_pkg::SLICE_W-1:0]      csr_wr_data
);
   import fsts_pkg::*;

   localparam int unsigned AW  = $clog2(MAX_TASKS);
   localparam int unsigned CW  = AW + 1;
   localparam int unsigned CNW = $clog2(MAX_TASKS + 1);
   localparam int unsigned WTW = WEIGHT_W + CNW;
   localparam int unsigned NW  = DIV_NUM_W;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_ENQW  = 4'd1;
   localparam logic [3:0] S_RD    = 4'd2;
   localparam logic [3:0] S_CHK   = 4'd3;
   localparam logic [3:0] S_MUL   = 4'd4;
   localparam logic [3:0] S_DIVW  = 4'd5;
   localparam logic [3:0] S_SCAN  = 4'd6;
   localparam logic [3:0] S_PICK  = 4'd7;
   localparam logic [3:0] S_CLR   = 4'd8;
   localparam logic [3:0] S_RESP  = 4'd9;

   // state
   logic [3:0]            state_ff, state_in;
   logic [2:0]            op_ff, op_in;
   logic [AW-1:0]         slot_ff, slot_in;
   logic [5:0]            prio_ff, prio_in;
   logic [RUNTIME_W-1:0]  runtime_ff, runtime_in;
   logic                  runnable_ff, runnable_in;
   logic [MAX_TASKS-1:0]  queued_ff, queued_in;
   logic [STAMP_W-1:0]    stamp_ff, stamp_in;
   logic [VR_W-1:0]       floor_ff, floor_in;
   logic [WTW-1:0]        wtot_ff, wtot_in;
   logic [CNW-1:0]        count_ff, count_in;
   logic [SLICE_W-1:0]    latency_ff, latency_in;
   logic [SLICE_W-1:0]    min_slice_ff, min_slice_in;
   fsts_entry_type        entry_ff, entry_in;
   logic [36:0]           prod_ff, prod_in;
   // scan
   logic                  pick_phase_ff, pick_phase_in;
   logic [CW-1:0]         scan_cnt_ff, scan_cnt_in;
   logic                  pend_ff, pend_in;
   logic [AW-1:0]         pend_idx_ff, pend_idx_in;
   logic                  found_ff, found_in;
   logic [AW-1:0]         best_idx_ff, best_idx_in;
   fsts_entry_type        best_ff, best_in;
   // result
   logic [1:0]            status_ff, status_in;
   logic [AW-1:0]         picked_ff, picked_in;
   logic [VR_W-1:0]       pvr_ff, pvr_in;
   logic [SLICE_W-1:0]    slice_ff, slice_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            o_status_ff, o_status_in;
   logic [3:0]            o_picked_ff, o_picked_in;
   logic [VR_W-1:0]       o_pvr_ff, o_pvr_in;
   logic [SLICE_W-1:0]    o_slice_ff, o_slice_in;
   logic [4:0]            o_count_ff, o_count_in;
   logic                  o_has_ff, o_has_in;

   // memory and divider wiring
   logic                  mem_we, mem_clr;
   logic [AW-1:0]         mem_waddr, mem_raddr;
   fsts_entry_type        mem_wdata, mem_rdata;
   logic                  div_start;
   logic [NW-1:0]         div_dividend, div_quot;
   logic [WTW-1:0]        div_divisor;
   fsts_div_stat_type     div_stat;

   // helpers
   logic                  accept;
   logic [AW-1:0]         req_slot;
   logic                  take;
   logic [VR_W:0]         vr_sum;
   logic [NW-1:0]         slice_src;
   logic [SLICE_W-1:0]    slice_val;
   logic [AW+3:0]         picked_ext;
   logic [CNW+4:0]        count_ext;
   logic                  clear_go;

   fsts_task_mem #(.MAX_TASKS(MAX_TASKS), .AW(AW)) u_mem (
      .clock (clock), .reset (reset), .clr (mem_clr),
      .we (mem_we), .waddr (mem_waddr), .wdata (mem_wdata),
      .raddr (mem_raddr), .rdata (mem_rdata)
   );

   fsts_div #(.NW(NW), .DW(WTW)) u_div (
      .clock (clock), .reset (reset), .start (div_start),
      .dividend (div_dividend), .divisor (div_divisor),
      .quotient (div_quot), .stat (div_stat)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign req_slot  = AW'(fold_id(req_task_id, MAX_TASKS));
   assign clear_go  = (state_ff == S_CLR);

   always_comb begin
      take = pend_ff && queued_ff[pend_idx_ff] &&
             (!found_ff || (mem_rdata.vruntime < best_ff.vruntime) ||
              ((mem_rdata.vruntime == best_ff.vruntime) &&
               (mem_rdata.stamp < best_ff.stamp)));
      vr_sum = {1'b0, entry_ff.vruntime} + (VR_W + 1)'(div_quot);
      slice_src = (state_ff == S_CHK) ? NW'(latency_ff) : div_quot;
      if (slice_src < NW'(min_slice_ff))       slice_val = min_slice_ff;
      else if (slice_src > NW'(SLICE_MAX))     slice_val = SLICE_MAX;
      else                                     slice_val = slice_src[SLICE_W-1:0];
      picked_ext = {4'd0, picked_ff};
      count_ext  = {5'd0, count_ff};
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      slot_in       = slot_ff;
      prio_in       = prio_ff;
      runtime_in    = runtime_ff;
      runnable_in   = runnable_ff;
      queued_in     = queued_ff;
      stamp_in      = stamp_ff;
      floor_in      = floor_ff;
      wtot_in       = wtot_ff;
      count_in      = count_ff;
      latency_in    = latency_ff;
      min_slice_in  = min_slice_ff;
      entry_in      = entry_ff;
      prod_in       = prod_ff;
      pick_phase_in = pick_phase_ff;
      scan_cnt_in   = scan_cnt_ff;
      pend_in       = 1'b0;
      pend_idx_in   = pend_idx_ff;
      found_in      = found_ff;
      best_idx_in   = best_idx_ff;
      best_in       = best_ff;
      status_in     = status_ff;
      picked_in     = picked_ff;
      pvr_in        = pvr_ff;
      slice_in      = slice_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      o_status_in   = o_status_ff;
      o_picked_in   = o_picked_ff;
      o_pvr_in      = o_pvr_ff;
      o_slice_in    = o_slice_ff;
      o_count_in    = o_count_ff;
      o_has_in      = o_has_ff;
      mem_we        = 1'b0;
      mem_clr       = 1'b0;
      mem_waddr     = slot_ff;
      mem_wdata     = entry_ff;
      mem_raddr     = slot_ff;
      div_start     = 1'b0;
      div_dividend  = {runtime_ff, UNIT_SHIFT'(0)};
      div_divisor   = WTW'(entry_ff.weight);

      if (csr_wr_en) begin
         if (csr_index == CSR_LATENCY) latency_in   = csr_wr_data;
         else                          min_slice_in = csr_wr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in       = req_opcode;
               slot_in     = req_slot;
               runtime_in  = req_runtime_ns;
               runnable_in = req_still_runnable;
               if (req_priority_req < 0)
                  prio_in = 6'd0;
               else if (req_priority_req > 7'sd39)
                  prio_in = 6'(PRIO_TOP);
               else
                  prio_in = 6'(req_priority_req);
               status_in     = STS_OK;
               picked_in     = '0;
               pvr_in        = '0;
               slice_in      = '0;
               scan_cnt_in   = '0;
               found_in      = 1'b0;
               pick_phase_in = 1'b0;
               case (req_opcode)
                  OP_ENQUEUE: begin
                     if (queued_ff[req_slot]) begin
                        status_in = STS_QUEUED;
                        state_in  = S_RESP;
                     end else begin
                        state_in = S_ENQW;
                     end
                  end
                  OP_PICK: begin
                     pick_phase_in = 1'b1;
                     state_in      = S_SCAN;
                  end
                  OP_PUTBACK: begin
                     if (queued_ff[req_slot]) begin
                        status_in = STS_QUEUED;
                        state_in  = S_RESP;
                     end else begin
                        state_in = S_RD;
                     end
                  end
                  OP_QUERY: state_in = S_RD;
                  OP_CLEAR: state_in = S_CLR;
                  default: begin
                     status_in = STS_BAD_OP;
                     state_in  = S_RESP;
                  end
               endcase
            end
         end
         S_ENQW: begin
            mem_we             = 1'b1;
            mem_wdata.vruntime = floor_ff;
            mem_wdata.weight   = weight_of(prio_ff);
            mem_wdata.stamp    = stamp_ff;
            queued_in[slot_ff] = 1'b1;
            stamp_in           = stamp_ff + 1'b1;
            wtot_in            = wtot_ff + WTW'(weight_of(prio_ff));
            count_in           = count_ff + 1'b1;
            state_in           = S_SCAN;
         end
         S_RD: state_in = S_CHK;
         S_CHK: begin
            entry_in = mem_rdata;
            prod_in  = 37'(latency_ff) * 37'(mem_rdata.weight);
            if (op_ff == OP_PUTBACK) begin
               state_in = (mem_rdata.weight == '0) ? S_RESP : S_MUL;
            end else if (wtot_ff == '0) begin
               slice_in = slice_val;
               state_in = S_RESP;
            end else begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            // divider start, operands from registered entry or product
            div_start = 1'b1;
            if (op_ff != OP_PUTBACK) begin
               div_dividend = NW'(prod_ff);
               div_divisor  = wtot_ff;
            end
            state_in = S_DIVW;
         end
         S_DIVW: begin
            if (div_stat.done) begin
               if (op_ff == OP_PUTBACK) begin
                  mem_we = 1'b1;
                  mem_wdata.vruntime = vr_sum[VR_W] ? '1 : vr_sum[VR_W-1:0];
                  if (runnable_ff) begin
                     mem_wdata.stamp    = stamp_ff;
                     queued_in[slot_ff] = 1'b1;
                     stamp_in           = stamp_ff + 1'b1;
                     wtot_in            = wtot_ff + WTW'(entry_ff.weight);
                     count_in           = count_ff + 1'b1;
                  end
                  state_in = S_SCAN;
               end else begin
                  slice_in = slice_val;
                  state_in = S_RESP;
               end
            end
         end
         S_SCAN: begin
            // read at scan_cnt, compare the entry addressed in the previous cycle
            mem_raddr = scan_cnt_ff[AW-1:0];
            if (scan_cnt_ff < CW'(MAX_TASKS)) begin
               pend_in     = 1'b1;
               pend_idx_in = scan_cnt_ff[AW-1:0];
               scan_cnt_in = scan_cnt_ff + 1'b1;
            end
            if (take) begin
               found_in    = 1'b1;
               best_idx_in = pend_idx_ff;
               best_in     = mem_rdata;
            end
            if (!pend_ff && (scan_cnt_ff == CW'(MAX_TASKS))) begin
               if (pick_phase_ff) begin
                  state_in = S_PICK;
               end else begin
                  if (found_ff && (best_ff.vruntime > floor_ff))
                     floor_in = best_ff.vruntime;
                  state_in = S_RESP;
               end
            end
         end
         S_PICK: begin
            if (!found_ff) begin
               status_in = STS_EMPTY;
               state_in  = S_RESP;
            end else begin
               queued_in[best_idx_ff] = 1'b0;
               wtot_in   = (wtot_ff >= WTW'(best_ff.weight)) ?
                           wtot_ff - WTW'(best_ff.weight) : '0;
               if (count_ff != '0) count_in = count_ff - 1'b1;
               picked_in     = best_idx_ff;
               pvr_in        = best_ff.vruntime;
               pick_phase_in = 1'b0;
               found_in      = 1'b0;
               scan_cnt_in   = '0;
               state_in      = S_SCAN;
            end
         end
         S_CLR: begin
            mem_clr   = 1'b1;
            queued_in = '0;
            stamp_in  = '0;
            floor_in  = '0;
            wtot_in   = '0;
            count_in  = '0;
            state_in  = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               o_status_in  = status_ff;
               o_picked_in  = picked_ext[3:0];
               o_pvr_in     = pvr_ff;
               o_slice_in   = slice_ff;
               o_count_in   = count_ext[4:0];
               o_has_in     = (count_ff != '0);
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      slot_ff     <= slot_in;
      prio_ff     <= prio_in;
      runtime_ff  <= runtime_in;
      runnable_ff <= runnable_in;
      entry_ff    <= entry_in;
      prod_ff     <= prod_in;
      pend_idx_ff <= pend_idx_in;
      best_idx_ff <= best_idx_in;
      best_ff     <= best_in;
      status_ff   <= status_in;
      picked_ff   <= picked_in;
      pvr_ff      <= pvr_in;
      slice_ff    <= slice_in;
      o_status_ff <= o_status_in;
      o_picked_ff <= o_picked_in;
      o_pvr_ff    <= o_pvr_in;
      o_slice_ff  <= o_slice_in;
      o_count_ff  <= o_count_in;
      o_has_ff    <= o_has_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         queued_ff     <= '0;
         stamp_ff      <= '0;
         floor_ff      <= '0;
         wtot_ff       <= '0;
         count_ff      <= '0;
         latency_ff    <= LATENCY_RST;
         min_slice_ff  <= MIN_SLICE_RST;
         pick_phase_ff <= 1'b0;
         scan_cnt_ff   <= '0;
         pend_ff       <= 1'b0;
         found_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         queued_ff     <= queued_in;
         stamp_ff      <= stamp_in;
         floor_ff      <= floor_in;
         wtot_ff       <= wtot_in;
         count_ff      <= count_in;
         latency_ff    <= latency_in;
         min_slice_ff  <= min_slice_in;
         pick_phase_ff <= pick_phase_in;
         scan_cnt_ff   <= scan_cnt_in;
         pend_ff       <= pend_in;
         found_ff      <= found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = o_status_ff;
   assign rsp_picked_task     = o_picked_ff;
   assign rsp_picked_vruntime = o_pvr_ff;
   assign rsp_timeslice_us    = o_slice_ff;
   assign rsp_queued_count    = o_count_ff;
   assign rsp_has_queued      = o_has_ff;

   `FSTS_ASSERT(a_count_matches_flags, clock, reset, ($countones(queued_ff) == 32'(count_ff)), "queue count out of step with queued flags")
   `FSTS_ASSERT(a_weight_tracks_count, clock, reset, ((count_ff != '0) == (wtot_ff != '0)), "weight total out of step with queue count")
   `FSTS_ASSERT(a_floor_monotonic, clock, reset, ((!$past(reset) && !$past(clear_go)) |-> (floor_ff >= $past(floor_ff))), "vruntime floor fell")
   `FSTS_ASSERT_NORST(a_div_start_idle, clock, (div_start |-> !div_stat.busy), "divider restarted while busy")

endmodule
